// File: hdl/pgmhf_pkg.sv
`default_nettype none

package pgmhf_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 4096;

   // row store holds one full row at most
   localparam int ROW_DEPTH = MAX_WIDTH;
   localparam int ROW_AW    = $clog2(ROW_DEPTH);

   localparam logic signed [15:0] MAX_WIDTH_S  = 16'(MAX_WIDTH);
   localparam logic signed [15:0] MAX_HEIGHT_S = 16'(MAX_HEIGHT);
   localparam logic signed [15:0] MAXVAL_S     = 16'sd255;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_NO_WIDTH   = 4'd1,
      ERR_NO_HEIGHT  = 4'd2,
      ERR_NOT_P2     = 4'd3,
      ERR_NO_MAXVAL  = 4'd4,
      ERR_EXTRA_DATA = 4'd5,
      ERR_PIX_RANGE  = 4'd6,
      ERR_WORD_PIX   = 4'd7,
      ERR_SIZE       = 4'd8
   } err_type;

   typedef enum logic [1:0] {
      PH_WIDTH  = 2'd0,
      PH_HEIGHT = 2'd1,
      PH_MAXVAL = 2'd2,
      PH_PIXELS = 2'd3
   } phase_type;

   typedef struct packed {
      logic              is_number;
      logic              is_p2_word;
      logic signed [15:0] token_value;
   } req_type;

   typedef struct packed {
      kind_type    out_kind;
      logic [7:0]  pixel_out;
      logic [6:0]  width_out;
      logic [12:0] height_out;
      err_type     error_code;
      logic [18:0] error_index;
      logic        last;
   } rsp_type;

   // parser to readout/output stage
   typedef struct packed {
      logic              emit;
      rsp_type           rsp;
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              row_done;
      logic [6:0]        row_len;
   } event_type;

endpackage

`default_nettype wire

// File: hdl/pgm_horizontal_flip.sv
`default_nettype none

// Mirrors each row of a plain-PGM (P2) image arriving as a token stream.
// The header (P2, width 1..64, height 1..4096, 255) produces one header
// transfer carrying width and height; after that every pixel token is
// written into a 64-entry row RAM, and when a row is complete it is read
// back in reverse column order, one pixel transfer per cycle while
// rsp_ready is high, with last set on the final pixel of the row. The
// first fault produces one error transfer (dense code, plus the pixel
// index for range and word faults) and latches: all later tokens are
// taken and dropped. Trailing words after the image are ignored; a short
// image is not reported. Rate: one token per cycle while no row ends and
// the rsp side does not stall. The token that ends a row holds req_ready
// low while the row RAM's single read port streams the row out, and a
// stalled rsp side holds it low longer; header and error transfers do not.
// Output is registered; a token is taken only when the output register is
// empty or its result leaves in the same cycle.

module pgm_horizontal_flip
   import pgmhf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   event_type         ev;
   logic              accept;
   logic              busy;
   logic              rd_en;
   logic [ROW_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   // no token during row readout; a token may need the output register
   assign req_ready = !busy && (!rsp_valid || rsp_ready);
   assign accept    = req_valid && req_ready;

   pgmhf_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .ev     (ev)
   );

   pgmhf_row_ram u_row_ram (
      .clock   (clock),
      .wr_en   (ev.wr_en),
      .wr_addr (ev.wr_addr),
      .wr_data (ev.wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pgmhf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ev        (ev),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/pgmhf_row_ram.sv
`default_nettype none

module pgmhf_row_ram
   import pgmhf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ROW_AW-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ROW_AW-1:0] rd_addr,
   output      logic [7:0]        rd_data
);

   logic [7:0] mem [ROW_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/pgmhf_parser.sv
`default_nettype none

module pgmhf_parser
   import pgmhf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output      event_type ev
);

   phase_type   phase_ff, phase_in;
   logic        magic_ff;
   logic [6:0]  width_ff;
   logic [12:0] height_ff;
   logic [18:0] total_ff;
   logic [18:0] seen_ff;
   logic [6:0]  col_ff;
   logic        err_ff;

   logic        fail;
   err_type     code;
   logic [18:0] idx;
   logic        set_magic;
   logic        adv;
   logic        store;
   logic        hdr;
   logic [6:0]  col_inc;
   logic        row_end;
   logic        v_nonpos;
   logic        v_pix_bad;

   assign col_inc   = col_ff + 7'd1;
   assign row_end   = (col_inc == width_ff);
   assign v_nonpos  = (req.token_value <= 16'sd0);
   assign v_pix_bad = req.token_value[15] || (req.token_value > MAXVAL_S);

   // token decode
   always_comb begin
      fail      = 1'b0;
      code      = ERR_NONE;
      idx       = '0;
      set_magic = 1'b0;
      adv       = 1'b0;
      store     = 1'b0;
      hdr       = 1'b0;
      if (accept && !err_ff) begin
         if (!req.is_number) begin
            case (phase_ff)
               PH_WIDTH: begin
                  if (req.is_p2_word) begin
                     set_magic = 1'b1;
                  end else begin
                     fail = 1'b1;
                     code = ERR_NOT_P2;
                  end
               end
               PH_PIXELS: begin
                  if (seen_ff < total_ff) begin
                     fail = 1'b1;
                     code = ERR_WORD_PIX;
                     idx  = seen_ff;
                  end
               end
               default: begin
                  fail = 1'b1;
                  code = ERR_WORD_PIX;
               end
            endcase
         end else begin
            case (phase_ff)
               PH_WIDTH: begin
                  if (v_nonpos) begin
                     fail = 1'b1;
                     code = ERR_NO_WIDTH;
                  end else if (req.token_value > MAX_WIDTH_S) begin
                     fail = 1'b1;
                     code = ERR_SIZE;
                  end else begin
                     adv = 1'b1;
                  end
               end
               PH_HEIGHT: begin
                  if (v_nonpos) begin
                     fail = 1'b1;
                     code = ERR_NO_HEIGHT;
                  end else if (req.token_value > MAX_HEIGHT_S) begin
                     fail = 1'b1;
                     code = ERR_SIZE;
                  end else begin
                     adv = 1'b1;
                  end
               end
               PH_MAXVAL: begin
                  if (!magic_ff) begin
                     fail = 1'b1;
                     code = ERR_NOT_P2;
                  end else if (req.token_value != MAXVAL_S) begin
                     fail = 1'b1;
                     code = ERR_NO_MAXVAL;
                  end else begin
                     adv = 1'b1;
                     hdr = 1'b1;
                  end
               end
               default: begin
                  if (seen_ff >= total_ff) begin
                     fail = 1'b1;
                     code = ERR_EXTRA_DATA;
                  end else if (v_pix_bad) begin
                     fail = 1'b1;
                     code = ERR_PIX_RANGE;
                     idx  = seen_ff;
                  end else begin
                     store = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (adv) begin
         case (phase_ff)
            PH_WIDTH:  phase_in = PH_HEIGHT;
            PH_HEIGHT: phase_in = PH_MAXVAL;
            default:   phase_in = PH_PIXELS;
         endcase
      end
   end

   // event towards output stage
   always_comb begin
      ev                 = '0;
      ev.emit            = fail || hdr;
      ev.rsp.out_kind    = fail ? KIND_ERROR : KIND_HEADER;
      ev.rsp.width_out   = hdr ? width_ff : 7'd0;
      ev.rsp.height_out  = hdr ? height_ff : 13'd0;
      ev.rsp.error_code  = code;
      ev.rsp.error_index = idx;
      ev.rsp.last        = 1'b1;
      ev.wr_en           = store;
      ev.wr_addr         = col_ff[ROW_AW-1:0];
      ev.wr_data         = req.token_value[7:0];
      ev.row_done        = store && row_end;
      ev.row_len         = width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WIDTH;
         magic_ff  <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         seen_ff   <= '0;
         col_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (fail) begin
            err_ff <= 1'b1;
         end
         if (set_magic) begin
            magic_ff <= 1'b1;
         end
         if (adv && phase_ff == PH_WIDTH) begin
            width_ff <= req.token_value[6:0];
         end
         if (adv && phase_ff == PH_HEIGHT) begin
            height_ff <= req.token_value[12:0];
         end
         if (store) begin
            seen_ff <= seen_ff + 19'd1;
            col_ff  <= row_end ? 7'd0 : col_inc;
         end
      end
   end

   // registered from height_ff, so it settles before any pixel arrives
   always_ff @(posedge clock) begin
      total_ff <= 19'(width_ff) * 19'(height_ff);
   end

endmodule

`default_nettype wire

// File: hdl/pgmhf_out_stage.sv
`default_nettype none

module pgmhf_out_stage
   import pgmhf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire event_type         ev,
   input  wire logic [7:0]        rd_data,
   output      logic              rd_en,
   output      logic [ROW_AW-1:0] rd_addr,
   output      logic              busy,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_type           rsp_data
);

   logic [6:0]        left_ff;
   logic [ROW_AW-1:0] addr_ff;
   logic              pend_ff;
   logic              pend_last_ff;
   logic              out_valid_ff;
   rsp_type           out_data_ff;
   logic              move;
   rsp_type           pix_rsp;

   assign busy    = (left_ff != 7'd0) || pend_ff;
   assign move    = pend_ff && (!out_valid_ff || rsp_ready);
   assign rd_en   = (left_ff != 7'd0) && (!pend_ff || move);
   assign rd_addr = addr_ff;

   always_comb begin
      pix_rsp           = '0;
      pix_rsp.out_kind  = KIND_PIXEL;
      pix_rsp.pixel_out = rd_data;
      pix_rsp.last      = pend_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ev.row_done) begin
            left_ff <= ev.row_len;
            addr_ff <= ROW_AW'(ev.row_len - 7'd1);
         end else if (rd_en) begin
            left_ff <= left_ff - 7'd1;
            addr_ff <= addr_ff - ROW_AW'(1);
         end
         if (rd_en) begin
            pend_ff      <= 1'b1;
            pend_last_ff <= (left_ff == 7'd1);
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (ev.emit) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= ev.rsp;
         end else if (move) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= pix_rsp;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// File: tb/sv/pgm_horizontal_flip_checker.sv
`default_nettype none

module pgm_horizontal_flip_checker
   import pgmhf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           waiting,
   output int           checked
);

   // shadow of the parser state
   phase_type  ph;
   logic       saw_p2;
   logic       err_latched;
   logic [6:0] img_w;
   logic [12:0] img_h;
   int         pix_seen;
   int         col;
   logic [7:0] row_mem [MAX_WIDTH];

   rsp_type    due_q [$];
   int         n_bad = 0;
   int         n_checked = 0;

   task automatic queue_result(input rsp_type r);
      due_q.insert(due_q.size(), r);
   endtask

   task automatic flag_fault(input err_type code, input int idx);
      rsp_type r;
      r             = '0;
      r.out_kind    = KIND_ERROR;
      r.error_code  = code;
      r.error_index = 19'(idx);
      r.last        = 1'b1;
      queue_result(r);
      err_latched = 1'b1;
   endtask

   task automatic mirror_step(input req_type t);
      int      total;
      int      v;
      int      i;
      rsp_type r;
      total = int'(img_w) * int'(img_h);
      v     = int'(t.token_value);
      if (err_latched)
         return;

      if (!t.is_number) begin
         if (ph == PH_WIDTH) begin
            if (t.is_p2_word)
               saw_p2 = 1'b1;
            else
               flag_fault(ERR_NOT_P2, 0);
         end else if (ph != PH_PIXELS) begin
            flag_fault(ERR_WORD_PIX, 0);
         end else if (pix_seen < total) begin
            flag_fault(ERR_WORD_PIX, pix_seen);
         end
         return;
      end

      case (ph)
         PH_WIDTH: begin
            if (v <= 0)
               flag_fault(ERR_NO_WIDTH, 0);
            else if (v > MAX_WIDTH)
               flag_fault(ERR_SIZE, 0);
            else begin
               img_w = 7'(v);
               ph    = PH_HEIGHT;
            end
         end
         PH_HEIGHT: begin
            if (v <= 0)
               flag_fault(ERR_NO_HEIGHT, 0);
            else if (v > MAX_HEIGHT)
               flag_fault(ERR_SIZE, 0);
            else begin
               img_h = 13'(v);
               ph    = PH_MAXVAL;
            end
         end
         PH_MAXVAL: begin
            if (!saw_p2)
               flag_fault(ERR_NOT_P2, 0);
            else if (v != int'(MAXVAL_S))
               flag_fault(ERR_NO_MAXVAL, 0);
            else begin
               ph           = PH_PIXELS;
               r            = '0;
               r.out_kind   = KIND_HEADER;
               r.width_out  = img_w;
               r.height_out = img_h;
               r.last       = 1'b1;
               queue_result(r);
            end
         end
         default: begin
            // extra data is checked ahead of the pixel range
            if (pix_seen >= total)
               flag_fault(ERR_EXTRA_DATA, 0);
            else if (v < 0 || v > int'(MAXVAL_S))
               flag_fault(ERR_PIX_RANGE, pix_seen);
            else begin
               row_mem[col] = t.token_value[7:0];
               pix_seen++;
               col++;
               if (col >= int'(img_w)) begin
                  col = 0;
                  for (i = 0; i < int'(img_w); i++) begin
                     r           = '0;
                     r.out_kind  = KIND_PIXEL;
                     r.pixel_out = row_mem[int'(img_w) - 1 - i];
                     r.last      = (i == int'(img_w) - 1);
                     queue_result(r);
                  end
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         ph          = PH_WIDTH;
         saw_p2      = 1'b0;
         err_latched = 1'b0;
         img_w       = '0;
         img_h       = '0;
         pix_seen    = 0;
         col         = 0;
         due_q.delete();
      end else begin
         if (req_valid && req_ready)
            mirror_step(req_data);
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (due_q.size() == 0) begin
               if (n_bad < 10)
                  $display("%0t: unexpected result kind=%0d pix=%0d code=%0d last=%0d",
                           $time, rsp_data.out_kind, rsp_data.pixel_out,
                           rsp_data.error_code, rsp_data.last);
               n_bad++;
            end else begin
               want = due_q.pop_front();
               if (rsp_data.out_kind    !== want.out_kind   ||
                   rsp_data.pixel_out   !== want.pixel_out  ||
                   rsp_data.width_out   !== want.width_out  ||
                   rsp_data.height_out  !== want.height_out ||
                   rsp_data.error_code  !== want.error_code ||
                   rsp_data.error_index !== want.error_index ||
                   rsp_data.last        !== want.last) begin
                  if (n_bad < 10) begin
                     $write("%0t: result %0d mismatch: expected kind=%0d pix=%0d ",
                            $time, n_checked, want.out_kind, want.pixel_out);
                     $write("w=%0d h=%0d code=%0d idx=%0d last=%0d, ",
                            want.width_out, want.height_out, want.error_code,
                            want.error_index, want.last);
                     $display("got kind=%0d pix=%0d w=%0d h=%0d code=%0d idx=%0d last=%0d",
                              rsp_data.out_kind, rsp_data.pixel_out,
                              rsp_data.width_out, rsp_data.height_out,
                              rsp_data.error_code, rsp_data.error_index,
                              rsp_data.last);
                  end
                  n_bad++;
               end
            end
         end
      end
      mismatches <= n_bad;
      waiting    <= due_q.size();
      checked    <= n_checked;
   end

endmodule

`default_nettype wire

// File: tb/sv/pgm_horizontal_flip_tb.sv
`default_nettype none

module pgm_horizontal_flip_tb;
   import pgmhf_pkg::*;

   // How the token stream ends. Reset is applied once only, and the first
   // fault latches, so each run walks one image and ends in one way.
   typedef enum int {
      END_HEADER_FAULT,
      END_RANGE_FAULT,
      END_WORD_FAULT,
      END_EXTRA_NUMBER,
      END_CLEAN,
      END_SHORT
   } ending_type;

   // Ways to break the header; each stops the run before any pixel.
   typedef enum int {
      HF_BAD_WORD,
      HF_NO_MAGIC,
      HF_WIDTH_LOW,
      HF_WIDTH_HIGH,
      HF_HEIGHT_LOW,
      HF_HEIGHT_HIGH,
      HF_WORD_AFTER_WIDTH,
      HF_WORD_AFTER_HEIGHT,
      HF_BAD_MAXVAL
   } hdr_fault_type;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 40;   // tokens sent before the long stall

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      mismatches;
   int      waiting;
   int      checked;

   int      tokens_sent = 0;
   int      burst_left  = 0;

   pgm_horizontal_flip dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pgm_horizontal_flip_checker mirror_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .waiting    (waiting),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic req_type tok(input logic num, input logic p2, input logic [15:0] val);
      req_type t;
      t.is_number   = num;
      t.is_p2_word  = p2;
      t.token_value = val;
      return t;
   endfunction

   // Offer one token and hold it until the transfer. The sender runs in
   // bursts; between bursts valid drops for a random gap (sometimes none).
   task automatic send_token(input req_type t);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do
         @(posedge clock);
      while (!req_ready);
      burst_left--;
      tokens_sent++;
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_token(tok(coin(), coin(), 16'($urandom)));
   endtask

   // Receiver: switches between four stall patterns at random.
   // Once, early in the pixel stream, it holds off for a long stretch so
   // the row readout backs up and the block has to stall its input.
   initial begin : receiver
      int span;
      int mode;
      bit held;
      held = 1'b0;
      forever begin
         span = $urandom_range(16, 64);
         mode = $urandom_range(0, 3);
         repeat (span) begin
            @(posedge clock);
            if (!held && tokens_sent >= HOLD_OFF_AFTER) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
            end
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= coin();
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      ending_type    ending;
      hdr_fault_type hf;
      int            pick;
      int            w;
      int            h;
      int            declared_h;
      int            total;
      int            fault_at;
      int            i;
      logic [15:0]   val;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      pick = $urandom_range(0, 11);
      case (pick)
         0:       ending = END_HEADER_FAULT;
         1, 2:    ending = END_RANGE_FAULT;
         3, 4:    ending = END_WORD_FAULT;
         5, 6, 7: ending = END_EXTRA_NUMBER;
         8, 9:    ending = END_CLEAN;
         default: ending = END_SHORT;
      endcase

      // widths at both extremes get a fair share
      case ($urandom_range(0, 3))
         0:       w = 1;
         1:       w = MAX_WIDTH;
         default: w = $urandom_range(2, MAX_WIDTH - 1);
      endcase
      h          = 240 / w;
      declared_h = h;
      hf         = HF_BAD_WORD;

      if (ending == END_HEADER_FAULT) begin
         hf = hdr_fault_type'($urandom_range(0, 8));
         if (hf == HF_BAD_WORD) begin
            send_token(tok(1'b0, 1'b0, 16'($urandom)));
         end else begin
            // a number before any P2 is taken as the width
            if (hf != HF_NO_MAGIC)
               send_token(tok(1'b0, 1'b1, 16'($urandom)));
            case (hf)
               HF_WIDTH_LOW:
                  send_token(tok(1'b1, coin(), 16'(0 - $urandom_range(0, 32768))));
               HF_WIDTH_HIGH:
                  send_token(tok(1'b1, coin(), 16'($urandom_range(MAX_WIDTH + 1, 32767))));
               default: begin
                  send_token(tok(1'b1, coin(), 16'(w)));
                  case (hf)
                     HF_HEIGHT_LOW:
                        send_token(tok(1'b1, coin(),
                                       16'(0 - $urandom_range(0, 32768))));
                     HF_HEIGHT_HIGH:
                        send_token(tok(1'b1, coin(),
                                       16'($urandom_range(MAX_HEIGHT + 1, 32767))));
                     HF_WORD_AFTER_WIDTH:
                        send_token(tok(1'b0, coin(), 16'($urandom)));
                     default: begin
                        send_token(tok(1'b1, coin(), 16'(h)));
                        if (hf == HF_WORD_AFTER_HEIGHT) begin
                           send_token(tok(1'b0, coin(), 16'($urandom)));
                        end else if (hf == HF_NO_MAGIC) begin
                           // missing P2 only shows on the third number
                           send_token(tok(1'b1, coin(), MAXVAL_S));
                        end else begin
                           val = 16'($urandom);
                           if (val == MAXVAL_S)
                              val = val + 16'd1;
                           send_token(tok(1'b1, coin(), val));
                        end
                     end
                  endcase
               end
            endcase
         end
         // all of this is dropped once the fault has latched
         send_noise(250);
      end else begin
         // a short image declares the tallest height and stops early
         if (ending == END_SHORT && coin())
            declared_h = MAX_HEIGHT;

         // header, with repeated P2 words now and then
         repeat ($urandom_range(1, 3)) send_token(tok(1'b0, 1'b1, 16'($urandom)));
         send_token(tok(1'b1, coin(), 16'(w)));
         send_token(tok(1'b1, coin(), 16'(declared_h)));
         send_token(tok(1'b1, coin(), MAXVAL_S));

         total    = w * h;
         fault_at = -1;
         if (ending == END_RANGE_FAULT || ending == END_WORD_FAULT)
            fault_at = $urandom_range(total / 2, total - 1);

         for (i = 0; i < total; i++) begin
            if (i == fault_at)
               break;
            // pixel extremes first, then mostly random with extremes mixed in
            if (i == 0)
               val = 16'd0;
            else if (i == 1)
               val = 16'd255;
            else case ($urandom_range(0, 7))
               0:       val = 16'd0;
               1:       val = 16'd255;
               default: val = 16'($urandom_range(0, 255));
            endcase
            send_token(tok(1'b1, coin(), val));
         end

         case (ending)
            END_RANGE_FAULT: begin
               val = coin() ? 16'(-1 - $urandom_range(0, 32767))
                            : 16'($urandom_range(256, 32767));
               send_token(tok(1'b1, coin(), val));
            end
            END_WORD_FAULT:
               send_token(tok(1'b0, coin(), 16'($urandom)));
            END_EXTRA_NUMBER, END_CLEAN: begin
               // trailing words after a full image are ignored
               if (declared_h == h)
                  repeat ($urandom_range(1, 5))
                     send_token(tok(1'b0, coin(), 16'($urandom)));
               // extra data outranks a bad pixel value
               if (ending == END_EXTRA_NUMBER)
                  send_token(tok(1'b1, coin(), 16'($urandom)));
            end
            default: ;
         endcase
         send_noise(20);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
      // let any stray transfer surface: a full row readout and then some
      repeat (2 * MAX_WIDTH + 8) @(posedge clock);

      $display("Run covered %0d tokens: ending %s (header case %s), image %0dx%0d of %0d rows",
               tokens_sent, ending.name(), hf.name(), w, h, declared_h);
      $display("%0d result transfers compared, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && waiting == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hdl/pgmhf_pkg.sv
hdl/pgmhf_row_ram.sv
hdl/pgmhf_parser.sv
hdl/pgmhf_out_stage.sv
hdl/pgm_horizontal_flip.sv
tb/sv/pgm_horizontal_flip_checker.sv
tb/sv/pgm_horizontal_flip_tb.sv
